>>> rtl/ict_pkg.sv
// ----------------------------------------------------------------------------
// ict_pkg: shared types and constants for the interval coverage tracker
// Table depth, offset width, command codes and the sequencer state type.
// ----------------------------------------------------------------------------
package ict_pkg;

  localparam int MaxRanges = 16;
  localparam int IdxW      = $clog2(MaxRanges);
  localparam int CntW      = $clog2(MaxRanges + 1);
  localparam int OffW      = 64;
  localparam int RcW       = 5;

  localparam logic [OffW-1:0] Top = {OffW{1'b1}};

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SCAN  = 8'b0000_0010,
    ST_EVAL  = 8'b0000_0100,
    ST_MOVE  = 8'b0000_1000,
    ST_MOVEW = 8'b0001_0000,
    ST_STORE = 8'b0010_0000,
    ST_DONE  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  // one entry compared against the item
  typedef struct packed {
    logic below;    // entry ends before a-1 (not touching)
    logic reach;    // entry starts at or before b+1
    logic has_s;    // entry holds a
    logic has_e;    // entry holds b
  } cmp_t;

endpackage

>>> rtl/ict_ram.sv
// ----------------------------------------------------------------------------
// ict_ram: generic single-port-write, one-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module ict_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ict_cmp.sv
// ----------------------------------------------------------------------------
// ict_cmp: shared compare unit
// Compares one stored range against the item's bounds each cycle.
// ----------------------------------------------------------------------------
module ict_cmp (
  input  logic [63:0]  ent_s,
  input  logic [63:0]  ent_e,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output ict_pkg::cmp_t res
);
  import ict_pkg::*;

  always_comb begin
    res.below = (ent_e != Top) && ((ent_e + 64'd1) < a);
    res.reach = (b == Top) || (ent_s <= (b + 64'd1));
    res.has_s = (ent_s <= a) && (a <= ent_e);
    res.has_e = (ent_s <= b) && (b <= ent_e);
  end

endmodule

>>> rtl/interval_coverage_tracker.sv
// ----------------------------------------------------------------------------
// interval_coverage_tracker: sorted table of received byte ranges
// Add, check and clear of disjoint ranges with a completeness flag.
// ----------------------------------------------------------------------------
// An item reads the table one entry at a time through a single compare unit
// (each entry is read from RAM in SCAN, then compared in EVAL); an add then
// shifts the tail entries, each read in MOVE and written in MOVEW, and stores
// the merged range. The block takes no new word until the result word has
// been taken. No clearing pass.
module interval_coverage_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_file_size,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_range_start,
  input  logic [63:0] in_range_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_exists,
  output logic        out_complete,
  output logic        out_overflow,
  output logic [4:0]  out_range_count
);
  import ict_pkg::*;

  state_t          st_r, st_nxt;
  logic [63:0]     fsize_r;
  logic [CntW-1:0] cnt_r;
  cmd_t            cmd_r;
  logic [63:0]     a_r, b_r, ns_r, ne_r;
  logic [CntW-1:0] i_r, lo_r, hi_r, mv_r;
  logic            lo_done_r, ex_r, ov_r, zl_r, rd_ph_r;
  logic [63:0]     s0_r, e0_r;   // copy of entry 0 for the complete flag
  logic            ok_r;

  logic [IdxW-1:0] raddr, waddr;
  logic            we;
  logic [63:0]     wd_s, wd_e, rd_s, rd_e;
  cmp_t            cr;

  ict_ram #(.Width(OffW), .Depth(MaxRanges)) u_s (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wd_s), .raddr(raddr), .rdata(rd_s));
  ict_ram #(.Width(OffW), .Depth(MaxRanges)) u_e (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wd_e), .raddr(raddr), .rdata(rd_e));

  ict_cmp u_cmp (.ent_s(rd_s), .ent_e(rd_e), .a(a_r), .b(b_r), .res(cr));

  logic [63:0] lm1, blast;
  assign lm1   = in_range_length - 64'd1;
  assign blast = (in_range_length == 64'd0) ? in_range_start :
                 (lm1 > (Top - in_range_start)) ? Top : in_range_start + lm1;

  logic [CntW-1:0] k, newcnt, src, dst, lo_f, hi_f;
  logic            ins, scan_end, ovf_now, move_now;
  assign k      = hi_r - lo_r;
  assign newcnt = cnt_r - k + CntW'(1);
  // a pure insert shifts the tail up, so it walks from the top down
  assign ins    = (hi_r == lo_r);
  assign src    = ins ? (cnt_r - CntW'(1) - mv_r) : (hi_r + mv_r);
  assign dst    = ins ? (src + CntW'(1)) : (lo_r + CntW'(1) + mv_r);

  assign scan_end = (cmd_r == CMD_CLEAR) || (cmd_r == CMD_NOP) ||
                    (cmd_r == CMD_ADD && zl_r) || (i_r >= cnt_r);
  assign lo_f     = lo_done_r ? lo_r : i_r;
  assign hi_f     = lo_done_r ? hi_r : i_r;
  assign ovf_now  = (hi_f == lo_f) && (cnt_r >= CntW'(MaxRanges));
  assign move_now = (hi_f < cnt_r);

  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = (st_r == ST_OUT);

  always_comb begin
    raddr = i_r[IdxW-1:0];
    we    = 1'b0;
    waddr = lo_r[IdxW-1:0];
    wd_s  = ns_r;
    wd_e  = ne_r;
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (in_valid) st_nxt = ST_SCAN;
      ST_SCAN:  begin
        if (!scan_end) begin
          st_nxt = ST_EVAL;
        end else if (cmd_r == CMD_ADD && !zl_r) begin
          st_nxt = ovf_now ? ST_DONE : (move_now ? ST_MOVE : ST_STORE);
        end else begin
          st_nxt = ST_DONE;
        end
      end
      ST_EVAL:  st_nxt = ST_SCAN;
      ST_MOVE:  begin
        raddr  = src[IdxW-1:0];
        st_nxt = ST_MOVEW;
      end
      ST_MOVEW: begin
        raddr = src[IdxW-1:0];
        we    = 1'b1;
        waddr = dst[IdxW-1:0];
        wd_s  = rd_s;
        wd_e  = rd_e;
        st_nxt = ((mv_r + CntW'(1)) < (cnt_r - hi_r)) ? ST_MOVE : ST_STORE;
      end
      ST_STORE: begin
        we     = 1'b1;
        st_nxt = ST_DONE;
      end
      ST_DONE:  st_nxt = ST_OUT;
      ST_OUT:   if (!out_stall) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      cnt_r   <= '0;
      fsize_r <= '0;
    end else begin
      if (cfg_we) fsize_r <= cfg_file_size;
      st_r <= st_nxt;
      case (st_r)
        ST_IDLE: if (in_valid) begin
          cmd_r <= cmd_t'(in_cmd);
          a_r   <= in_range_start;
          b_r   <= blast;
          zl_r  <= (in_range_length == 64'd0);
          ns_r  <= in_range_start;
          ne_r  <= blast;
          i_r   <= '0;
          lo_r  <= '0;
          hi_r  <= '0;
          mv_r  <= '0;
          lo_done_r <= 1'b0;
          ex_r  <= 1'b0;
          ov_r  <= 1'b0;
        end
        ST_SCAN: begin
          // clear, nop, zero-length add, or end of table: finish scan
          if (scan_end) begin
            if (cmd_r == CMD_CLEAR) cnt_r <= '0;
            if (cmd_r == CMD_ADD && !zl_r) begin
              if (!lo_done_r) begin
                lo_r <= i_r;
                hi_r <= i_r;
              end
              if (ovf_now) ov_r <= 1'b1;
            end
          end
        end
        ST_EVAL: begin
          if (i_r == '0) begin
            s0_r <= rd_s;
            e0_r <= rd_e;
          end
          if (cmd_r == CMD_CHECK) begin
            i_r <= i_r + CntW'(1);
            if (cr.has_s || cr.has_e) ex_r <= 1'b1;
          end else if (!lo_done_r) begin
            if (!cr.below) begin
              lo_done_r <= 1'b1;
              lo_r <= i_r;
              if (cr.reach) begin
                hi_r <= i_r + CntW'(1);
                i_r  <= i_r + CntW'(1);
                if (rd_s < a_r) ns_r <= rd_s;
                if (rd_e > b_r) ne_r <= rd_e;
              end else begin
                // first non-left entry lies beyond: scan is over
                hi_r <= i_r;
                i_r  <= cnt_r;
              end
            end else begin
              i_r <= i_r + CntW'(1);
            end
          end else if (cr.reach) begin
            hi_r <= i_r + CntW'(1);
            i_r  <= i_r + CntW'(1);
            if (rd_e > ne_r) ne_r <= rd_e;
          end else begin
            i_r <= cnt_r;
          end
        end
        ST_MOVEW: begin
          mv_r <= mv_r + CntW'(1);
        end
        ST_STORE: begin
          cnt_r <= newcnt;
          if (lo_r == '0) begin
            s0_r <= ns_r;
            e0_r <= ne_r;
          end
        end
        default: ;
      endcase
    end
  end

  // entry 0 copy is fresh whenever count is 1 (it was scanned or stored)
  always_ff @(posedge clk) begin
    if (st_r == ST_DONE) begin
      out_exists      <= ex_r;
      out_overflow    <= ov_r;
      out_range_count <= RcW'(cnt_r);
      out_complete    <= (fsize_r == 64'd0) ||
                         (cnt_r == CntW'(1) && s0_r == 64'd0 && e0_r >= fsize_r - 64'd1);
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= rst_n;
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxRanges)) else $error("count above depth");
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> out_range_count == RcW'(MaxRanges))
    else $error("overflow with room left");
  a_ex: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_exists) |-> cmd_r == CMD_CHECK) else $error("exists on non-check");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n || !ok_r)
    (out_valid && out_stall) |=> out_valid && $stable(out_range_count))
    else $error("result dropped");

endmodule
